// ===== src/rmac_pkg.sv =====
package rmac_pkg;

    // fixed-point format and sizes
    localparam int FRAC_BITS  = 40;
    localparam int FX_W       = 64;
    localparam int IN_W       = 32;
    localparam int IN_FRAC    = 24;
    localparam int ITER_W     = 11;
    localparam int CLASS_W    = 3;
    localparam int HIST_DEPTH = 1024;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int RF_DEPTH   = 16;
    localparam int RF_AW      = $clog2(RF_DEPTH);
    localparam int SRC_W      = RF_AW + 1;
    localparam int PC_W       = 7;

    localparam logic [ITER_W-1:0] MAX_ITER_RESET = ITER_W'(1000);
    localparam logic [ITER_W-1:0] ITER_LIMIT     = ITER_W'(HIST_DEPTH);

    localparam logic [FX_W-1:0] FX_MAX = {1'b0, {(FX_W-1){1'b1}}};
    localparam logic [FX_W-1:0] FX_MIN = {1'b1, {(FX_W-1){1'b0}}};
    localparam logic [FX_W-1:0] FX_ONE = FX_W'(1) << FRAC_BITS;

    // near and escape thresholds on squared norms
    localparam logic [FX_W-1:0] SMALL_RAW =
        ((64'd1 << FRAC_BITS) + 64'd5000000000) / 64'd10000000000;
    localparam logic [FX_W-1:0] SMALL_LIMIT = (SMALL_RAW == '0) ? FX_W'(1) : SMALL_RAW;
    localparam logic [FX_W-1:0] BIG_LIMIT =
        (FRAC_BITS <= 29) ? (64'd10000000000 << FRAC_BITS) : FX_MAX;

    // result codes
    localparam logic [CLASS_W-1:0] CLASS_CYCLE     = CLASS_W'(3);
    localparam logic [CLASS_W-1:0] CLASS_UNDECIDED = CLASS_W'(4);

    // micro-op codes
    typedef enum logic [3:0] {
        OP_ADD,
        OP_SUB,
        OP_NEG,
        OP_MUL,
        OP_DIV,
        OP_CHKZ,
        OP_NEAR0,
        OP_ESC,
        OP_NEAR1,
        OP_CYC,
        OP_INIT,
        OP_LOOP,
        OP_NEXT
    } op_t;

    // operand sources: register file entries, then constants and memories
    localparam logic [SRC_W-1:0] S_AR   = SRC_W'(0);
    localparam logic [SRC_W-1:0] S_AI   = SRC_W'(1);
    localparam logic [SRC_W-1:0] S_PR   = SRC_W'(2);
    localparam logic [SRC_W-1:0] S_PI   = SRC_W'(3);
    localparam logic [SRC_W-1:0] S_ZR   = SRC_W'(4);
    localparam logic [SRC_W-1:0] S_ZI   = SRC_W'(5);
    localparam logic [SRC_W-1:0] S_N    = SRC_W'(6);
    localparam logic [SRC_W-1:0] S_WR   = SRC_W'(7);
    localparam logic [SRC_W-1:0] S_WI   = SRC_W'(8);
    localparam logic [SRC_W-1:0] S_T0   = SRC_W'(9);
    localparam logic [SRC_W-1:0] S_T1   = SRC_W'(10);
    localparam logic [SRC_W-1:0] S_T2   = SRC_W'(11);
    localparam logic [SRC_W-1:0] S_T3   = SRC_W'(12);
    localparam logic [SRC_W-1:0] S_UR   = SRC_W'(13);
    localparam logic [SRC_W-1:0] S_UI   = SRC_W'(14);
    localparam logic [SRC_W-1:0] S_ONE  = SRC_W'(16);
    localparam logic [SRC_W-1:0] S_ZERO = SRC_W'(17);
    localparam logic [SRC_W-1:0] S_INRE = SRC_W'(18);
    localparam logic [SRC_W-1:0] S_INIM = SRC_W'(19);
    localparam logic [SRC_W-1:0] S_HRE  = SRC_W'(20);
    localparam logic [SRC_W-1:0] S_HIM  = SRC_W'(21);

    localparam logic [PC_W-1:0] LOOP_PC = PC_W'(20);

    typedef struct packed {
        op_t              op;
        logic [RF_AW-1:0] dst;
        logic [SRC_W-1:0] srca;
        logic [SRC_W-1:0] srcb;
        logic             hre;
        logic             him;
    } uop_t;

    // handshake between sequencer and arithmetic unit
    typedef struct packed {
        logic start;
        op_t  op;
    } alu_req_t;

    typedef struct packed {
        logic done;
    } alu_resp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RDA,
        ST_RDB,
        ST_EXEC,
        ST_WAIT,
        ST_OUT
    } seq_state_t;

    typedef enum logic [2:0] {
        AS_IDLE,
        AS_MUL,
        AS_MFIN,
        AS_DIV,
        AS_DFIN,
        AS_DRND
    } alu_state_t;

    function automatic uop_t mk(op_t op, logic [SRC_W-1:0] d, logic [SRC_W-1:0] a,
                                logic [SRC_W-1:0] b, logic hr, logic hi);
        uop_t u;
        u.op   = op;
        u.dst  = d[RF_AW-1:0];
        u.srca = a;
        u.srcb = b;
        u.hre  = hr;
        u.him  = hi;
        return u;
    endfunction

    // micro program: first orbit value, then the iteration loop
    function automatic uop_t uop_rom(logic [PC_W-1:0] pc);
        uop_t u;
        case (pc)
            // a, a+1 and its norm
            7'd0:  u = mk(OP_ADD,  S_AR, S_INRE, S_ZERO, 1'b0, 1'b0);
            7'd1:  u = mk(OP_ADD,  S_AI, S_INIM, S_ZERO, 1'b0, 1'b0);
            7'd2:  u = mk(OP_ADD,  S_PR, S_AR,   S_ONE,  1'b0, 1'b0);
            7'd3:  u = mk(OP_ADD,  S_PI, S_AI,   S_ZERO, 1'b0, 1'b0);
            7'd4:  u = mk(OP_MUL,  S_T0, S_PR,   S_PR,   1'b0, 1'b0);
            7'd5:  u = mk(OP_MUL,  S_T1, S_PI,   S_PI,   1'b0, 1'b0);
            7'd6:  u = mk(OP_ADD,  S_N,  S_T0,   S_T1,   1'b0, 1'b0);
            7'd7:  u = mk(OP_CHKZ, S_N,  S_N,    S_ZERO, 1'b0, 1'b0);
            // c = 2a * conj(a+1) / norm
            7'd8:  u = mk(OP_ADD,  S_T2, S_AR,   S_AR,   1'b0, 1'b0);
            7'd9:  u = mk(OP_ADD,  S_T3, S_AI,   S_AI,   1'b0, 1'b0);
            7'd10: u = mk(OP_NEG,  S_T0, S_PI,   S_ZERO, 1'b0, 1'b0);
            7'd11: u = mk(OP_MUL,  S_UR, S_T2,   S_PR,   1'b0, 1'b0);
            7'd12: u = mk(OP_MUL,  S_UI, S_T3,   S_T0,   1'b0, 1'b0);
            7'd13: u = mk(OP_SUB,  S_WR, S_UR,   S_UI,   1'b0, 1'b0);
            7'd14: u = mk(OP_MUL,  S_UR, S_T2,   S_T0,   1'b0, 1'b0);
            7'd15: u = mk(OP_MUL,  S_UI, S_T3,   S_PR,   1'b0, 1'b0);
            7'd16: u = mk(OP_ADD,  S_WI, S_UR,   S_UI,   1'b0, 1'b0);
            7'd17: u = mk(OP_DIV,  S_ZR, S_WR,   S_N,    1'b1, 1'b0);
            7'd18: u = mk(OP_DIV,  S_ZI, S_WI,   S_N,    1'b0, 1'b1);
            7'd19: u = mk(OP_INIT, S_N,  S_N,    S_ZERO, 1'b0, 1'b0);
            // loop head and 1/z
            7'd20: u = mk(OP_LOOP, S_N,  S_N,    S_ZERO, 1'b0, 1'b0);
            7'd21: u = mk(OP_MUL,  S_T0, S_ZR,   S_ZR,   1'b0, 1'b0);
            7'd22: u = mk(OP_MUL,  S_T1, S_ZI,   S_ZI,   1'b0, 1'b0);
            7'd23: u = mk(OP_ADD,  S_N,  S_T0,   S_T1,   1'b0, 1'b0);
            7'd24: u = mk(OP_CHKZ, S_N,  S_N,    S_ZERO, 1'b0, 1'b0);
            7'd25: u = mk(OP_DIV,  S_WR, S_ZR,   S_N,    1'b0, 1'b0);
            7'd26: u = mk(OP_DIV,  S_T0, S_ZI,   S_N,    1'b0, 1'b0);
            7'd27: u = mk(OP_NEG,  S_WI, S_T0,   S_ZERO, 1'b0, 1'b0);
            // u = (a+1) w
            7'd28: u = mk(OP_MUL,  S_T0, S_PR,   S_WR,   1'b0, 1'b0);
            7'd29: u = mk(OP_MUL,  S_T1, S_PI,   S_WI,   1'b0, 1'b0);
            7'd30: u = mk(OP_SUB,  S_UR, S_T0,   S_T1,   1'b0, 1'b0);
            7'd31: u = mk(OP_MUL,  S_T0, S_PR,   S_WI,   1'b0, 1'b0);
            7'd32: u = mk(OP_MUL,  S_T1, S_PI,   S_WR,   1'b0, 1'b0);
            7'd33: u = mk(OP_ADD,  S_UI, S_T0,   S_T1,   1'b0, 1'b0);
            // w squared
            7'd34: u = mk(OP_MUL,  S_T0, S_WR,   S_WR,   1'b0, 1'b0);
            7'd35: u = mk(OP_MUL,  S_T1, S_WI,   S_WI,   1'b0, 1'b0);
            7'd36: u = mk(OP_SUB,  S_T2, S_T0,   S_T1,   1'b0, 1'b0);
            7'd37: u = mk(OP_MUL,  S_T0, S_WR,   S_WI,   1'b0, 1'b0);
            7'd38: u = mk(OP_MUL,  S_T1, S_WI,   S_WR,   1'b0, 1'b0);
            7'd39: u = mk(OP_ADD,  S_T3, S_T0,   S_T1,   1'b0, 1'b0);
            // v = a w^2
            7'd40: u = mk(OP_MUL,  S_T0, S_AR,   S_T2,   1'b0, 1'b0);
            7'd41: u = mk(OP_MUL,  S_T1, S_AI,   S_T3,   1'b0, 1'b0);
            7'd42: u = mk(OP_SUB,  S_WR, S_T0,   S_T1,   1'b0, 1'b0);
            7'd43: u = mk(OP_MUL,  S_T0, S_AR,   S_T3,   1'b0, 1'b0);
            7'd44: u = mk(OP_MUL,  S_T1, S_AI,   S_T2,   1'b0, 1'b0);
            7'd45: u = mk(OP_ADD,  S_WI, S_T0,   S_T1,   1'b0, 1'b0);
            // new orbit value 1 - u + v
            7'd46: u = mk(OP_SUB,  S_T0, S_ONE,  S_UR,   1'b0, 1'b0);
            7'd47: u = mk(OP_ADD,  S_ZR, S_T0,   S_WR,   1'b1, 1'b0);
            7'd48: u = mk(OP_SUB,  S_T0, S_ZERO, S_UI,   1'b0, 1'b0);
            7'd49: u = mk(OP_ADD,  S_ZI, S_T0,   S_WI,   1'b0, 1'b1);
            // near zero and escape
            7'd50: u = mk(OP_MUL,  S_T0, S_ZR,   S_ZR,   1'b0, 1'b0);
            7'd51: u = mk(OP_MUL,  S_T1, S_ZI,   S_ZI,   1'b0, 1'b0);
            7'd52: u = mk(OP_ADD,  S_N,  S_T0,   S_T1,   1'b0, 1'b0);
            7'd53: u = mk(OP_NEAR0, S_N, S_N,    S_ZERO, 1'b0, 1'b0);
            7'd54: u = mk(OP_ESC,  S_N,  S_N,    S_ZERO, 1'b0, 1'b0);
            // near one
            7'd55: u = mk(OP_SUB,  S_T2, S_ZR,   S_ONE,  1'b0, 1'b0);
            7'd56: u = mk(OP_MUL,  S_T0, S_T2,   S_T2,   1'b0, 1'b0);
            7'd57: u = mk(OP_MUL,  S_T1, S_ZI,   S_ZI,   1'b0, 1'b0);
            7'd58: u = mk(OP_ADD,  S_N,  S_T0,   S_T1,   1'b0, 1'b0);
            7'd59: u = mk(OP_NEAR1, S_N, S_N,    S_ZERO, 1'b0, 1'b0);
            // cycle against history at half the index
            7'd60: u = mk(OP_SUB,  S_T2, S_ZR,   S_HRE,  1'b0, 1'b0);
            7'd61: u = mk(OP_SUB,  S_T3, S_ZI,   S_HIM,  1'b0, 1'b0);
            7'd62: u = mk(OP_MUL,  S_T0, S_T2,   S_T2,   1'b0, 1'b0);
            7'd63: u = mk(OP_MUL,  S_T1, S_T3,   S_T3,   1'b0, 1'b0);
            7'd64: u = mk(OP_ADD,  S_N,  S_T0,   S_T1,   1'b0, 1'b0);
            7'd65: u = mk(OP_CYC,  S_N,  S_N,    S_ZERO, 1'b0, 1'b0);
            7'd66: u = mk(OP_NEXT, S_N,  S_N,    S_ZERO, 1'b0, 1'b0);
            default: u = mk(OP_NEXT, S_N, S_N,   S_ZERO, 1'b0, 1'b0);
        endcase
        return u;
    endfunction

    // value mod 3, summing base-4 digits since 4 is 1 mod 3
    function automatic logic [1:0] mod3(logic [ITER_W:0] x);
        logic [2:0] r;
        r = 3'd0;
        for (int k = 0; k < (ITER_W + 1) / 2; k++) begin
            r = r + {1'b0, x[2*k +: 2]};
            if (r >= 3'd3) begin
                r = r - 3'd3;
            end
        end
        return r[1:0];
    endfunction

endpackage

// ===== src/rmac_point_if.sv =====
interface rmac_point_if;
    logic                                valid;
    logic                                ready;
    logic signed [rmac_pkg::IN_W-1:0]    point_re;
    logic signed [rmac_pkg::IN_W-1:0]    point_im;

    modport source (output valid, output point_re, output point_im, input ready);
    modport sink   (input valid, input point_re, input point_im, output ready);
endinterface

// ===== src/rmac_result_if.sv =====
interface rmac_result_if;
    logic                             valid;
    logic                             ready;
    logic [rmac_pkg::CLASS_W-1:0]     class_code;
    logic [rmac_pkg::ITER_W-1:0]      iterations_used;

    modport source (output valid, output class_code, output iterations_used, input ready);
    modport sink   (input valid, input class_code, input iterations_used, output ready);
endinterface

// ===== src/rmac_alu.sv =====
module rmac_alu (
    input  logic                           clk,
    input  logic                           rst_n,
    input  rmac_pkg::alu_req_t             req,
    input  logic [rmac_pkg::FX_W-1:0]      a,
    input  logic [rmac_pkg::FX_W-1:0]      b,
    output rmac_pkg::alu_resp_t            resp,
    output logic [rmac_pkg::FX_W-1:0]      result
);

    localparam int W = rmac_pkg::FX_W;
    localparam int F = rmac_pkg::FRAC_BITS;
    localparam int H = W / 2;

    function automatic logic [W-1:0] mag(logic [W-1:0] x);
        return x[W-1] ? (~x + W'(1)) : x;
    endfunction

    function automatic logic [W-1:0] sat(logic [W-1:0] m, logic neg, logic ovf);
        logic [W-1:0] mm;
        mm = (ovf || m[W-1]) ? rmac_pkg::FX_MAX : m;
        return neg ? (~mm + W'(1)) : mm;
    endfunction

    function automatic logic [W-1:0] sneg(logic [W-1:0] x);
        return (x == rmac_pkg::FX_MIN) ? rmac_pkg::FX_MAX : (~x + W'(1));
    endfunction

    function automatic logic [W-1:0] sadd(logic [W-1:0] x, logic [W-1:0] y);
        logic [W-1:0] r;
        r = x + y;
        if (!x[W-1] && !y[W-1] && r[W-1]) begin
            r = rmac_pkg::FX_MAX;
        end else if (x[W-1] && y[W-1] && !r[W-1]) begin
            r = rmac_pkg::FX_MIN;
        end
        return r;
    endfunction

    rmac_pkg::alu_state_t as_reg, as_next;
    logic [W-1:0]   ma_reg, ma_next;
    logic [W-1:0]   mb_reg, mb_next;
    logic           neg_reg, neg_next;
    logic [6:0]     cnt_reg, cnt_next;
    logic [W-1:0]   prod_reg, prod_next;
    logic [1:0]     psh_reg, psh_next;
    logic [2*W-1:0] acc_reg, acc_next;
    logic [2*W-1:0] dvd_reg, dvd_next;
    logic [W-1:0]   rem_reg, rem_next;
    logic [W-1:0]   q_reg, q_next;
    logic           ovf_reg, ovf_next;
    logic           rnd_reg, rnd_next;
    logic [W-1:0]   res_reg, res_next;
    logic           done_reg, done_next;

    logic [H-1:0]   ah, bh;
    logic [W:0]     remsh;
    logic [W-1:0]   qq;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            as_reg   <= rmac_pkg::AS_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            as_reg   <= as_next;
            done_reg <= done_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        ma_reg   <= ma_next;
        mb_reg   <= mb_next;
        neg_reg  <= neg_next;
        cnt_reg  <= cnt_next;
        prod_reg <= prod_next;
        psh_reg  <= psh_next;
        acc_reg  <= acc_next;
        dvd_reg  <= dvd_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        ovf_reg  <= ovf_next;
        rnd_reg  <= rnd_next;
        res_reg  <= res_next;
    end

    // sequencing of add, subtract, negate, multiply and divide
    always_comb
    begin
        as_next   = as_reg;
        ma_next   = ma_reg;
        mb_next   = mb_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        prod_next = prod_reg;
        psh_next  = psh_reg;
        acc_next  = acc_reg;
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        q_next    = q_reg;
        ovf_next  = ovf_reg;
        rnd_next  = rnd_reg;
        res_next  = res_reg;
        done_next = 1'b0;
        ah        = cnt_reg[1] ? ma_reg[W-1:H] : ma_reg[H-1:0];
        bh        = cnt_reg[0] ? mb_reg[W-1:H] : mb_reg[H-1:0];
        remsh     = {rem_reg, dvd_reg[2*W-1]};
        qq        = q_reg + W'(rnd_reg);

        case (as_reg)
            rmac_pkg::AS_IDLE:
            begin
                if (req.start)
                begin
                    case (req.op)
                        rmac_pkg::OP_ADD:
                        begin
                            res_next  = sadd(a, b);
                            done_next = 1'b1;
                        end
                        rmac_pkg::OP_SUB:
                        begin
                            res_next  = sadd(a, sneg(b));
                            done_next = 1'b1;
                        end
                        rmac_pkg::OP_NEG:
                        begin
                            res_next  = sneg(a);
                            done_next = 1'b1;
                        end
                        rmac_pkg::OP_MUL:
                        begin
                            ma_next  = mag(a);
                            mb_next  = mag(b);
                            neg_next = a[W-1] ^ b[W-1];
                            cnt_next = '0;
                            acc_next = (2*W)'(1) << (F - 1);
                            as_next  = rmac_pkg::AS_MUL;
                        end
                        rmac_pkg::OP_DIV:
                        begin
                            ma_next  = mag(a);
                            mb_next  = b;
                            neg_next = a[W-1];
                            dvd_next = {{W{1'b0}}, mag(a)} << F;
                            rem_next = '0;
                            q_next   = '0;
                            ovf_next = 1'b0;
                            cnt_next = '0;
                            as_next  = rmac_pkg::AS_DIV;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            // one 32x32 partial product a cycle, registered in prod_reg before it is accumulated
            rmac_pkg::AS_MUL:
            begin
                if (cnt_reg != '0)
                begin
                    acc_next = acc_reg + ({{W{1'b0}}, prod_reg} << (H * int'(psh_reg)));
                end
                if (cnt_reg < 7'd4)
                begin
                    prod_next = {{H{1'b0}}, ah} * {{H{1'b0}}, bh};
                    psh_next  = 2'(cnt_reg[1]) + 2'(cnt_reg[0]);
                    cnt_next  = cnt_reg + 7'd1;
                end
                else
                begin
                    as_next = rmac_pkg::AS_MFIN;
                end
            end

            rmac_pkg::AS_MFIN:
            begin
                res_next  = sat(acc_reg[F+W-1:F], neg_reg, |acc_reg[2*W-1:F+W]);
                done_next = 1'b1;
                as_next   = rmac_pkg::AS_IDLE;
            end

            // restoring division, one quotient bit a cycle
            rmac_pkg::AS_DIV:
            begin
                ovf_next = ovf_reg | q_reg[W-1];
                dvd_next = dvd_reg << 1;
                if (remsh >= {1'b0, mb_reg})
                begin
                    rem_next = W'(remsh - {1'b0, mb_reg});
                    q_next   = {q_reg[W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = remsh[W-1:0];
                    q_next   = {q_reg[W-2:0], 1'b0};
                end
                cnt_next = cnt_reg + 7'd1;
                if (cnt_reg == '1)
                begin
                    as_next = rmac_pkg::AS_DFIN;
                end
            end

            rmac_pkg::AS_DFIN:
            begin
                rnd_next = (rem_reg >= (mb_reg - rem_reg));
                as_next  = rmac_pkg::AS_DRND;
            end

            rmac_pkg::AS_DRND:
            begin
                res_next  = sat(qq, neg_reg, ovf_reg | (rnd_reg & (q_reg == '1)));
                done_next = 1'b1;
                as_next   = rmac_pkg::AS_IDLE;
            end

            default:
            begin
                as_next = rmac_pkg::AS_IDLE;
            end
        endcase
    end

    assign resp.done = done_reg;
    assign result    = res_reg;

endmodule

// ===== src/rational_map_attractor_classifier_core.sv =====
// Classifies one complex parameter a (point_re/point_im, Q8.24) per item by
// walking the orbit of z' = 1 - (a+1)/z + a/z^2 from c = 2a/(a+1) in Q24.40
// and returns a phase class 0..2 (near 0, escaped, near 1), 3 for a cycle
// against the value at half the index, or 4 for undecided or a zero divisor,
// together with the index at which the decision fell. One item is in work at
// a time: point_in.ready is high only when the block is idle, and stays low
// until the result has been taken. A small micro-program drives one shared
// arithmetic unit: a multiply is built from four 32x32 partial products, a
// divide from one quotient bit a cycle. The reset iteration limit is 1000.
// The user must write max_iterations through cfg_we/cfg_wdata only while
// idle; the block itself does not enforce this. Values above 1024 act as 1024.
module rational_map_attractor_classifier_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [rmac_pkg::ITER_W-1:0]        cfg_wdata,
    rmac_point_if.sink                         point_in,
    rmac_result_if.source                      result_out
);

    localparam int W  = rmac_pkg::FX_W;
    localparam int IW = rmac_pkg::ITER_W;

    rmac_pkg::seq_state_t state_reg, state_next;
    logic [rmac_pkg::PC_W-1:0]    pc_reg, pc_next;
    logic [IW-1:0]                iter_reg, iter_next;
    logic [IW-1:0]                max_iter_reg;
    logic [W-1:0]                 in_re_reg, in_re_next;
    logic [W-1:0]                 in_im_reg, in_im_next;
    logic [W-1:0]                 opa_reg, opa_next;
    logic                         out_valid_reg, out_valid_next;
    logic [rmac_pkg::CLASS_W-1:0] class_reg, class_next;
    logic [IW-1:0]                used_reg, used_next;

    logic [W-1:0] rf_mem [rmac_pkg::RF_DEPTH];
    logic [W-1:0] hre_mem [rmac_pkg::HIST_DEPTH];
    logic [W-1:0] him_mem [rmac_pkg::HIST_DEPTH];
    logic [W-1:0] rf_rd_reg;
    logic [W-1:0] hre_rd_reg;
    logic [W-1:0] him_rd_reg;

    rmac_pkg::uop_t       uop;
    rmac_pkg::alu_req_t   alu_req;
    rmac_pkg::alu_resp_t  alu_resp;
    logic [W-1:0]         alu_result;
    logic [W-1:0]         opb;
    logic [W-1:0]         opa_src;
    logic                 rf_we;
    logic [rmac_pkg::RF_AW-1:0]   rf_raddr;
    logic [rmac_pkg::HIST_AW-1:0] hist_waddr;
    logic [rmac_pkg::HIST_AW-1:0] hist_raddr;
    logic [IW-1:0]        lim;
    logic [IW:0]          phase_base;

    function automatic logic [W-1:0] pick(logic [rmac_pkg::SRC_W-1:0] s, logic [W-1:0] rf,
                                          logic [W-1:0] hr, logic [W-1:0] hi,
                                          logic [W-1:0] ir, logic [W-1:0] ii);
        logic [W-1:0] v;
        case (s)
            rmac_pkg::S_ONE:  v = rmac_pkg::FX_ONE;
            rmac_pkg::S_ZERO: v = '0;
            rmac_pkg::S_INRE: v = ir;
            rmac_pkg::S_INIM: v = ii;
            rmac_pkg::S_HRE:  v = hr;
            rmac_pkg::S_HIM:  v = hi;
            default:          v = rf;
        endcase
        return v;
    endfunction

    function automatic logic [W-1:0] load_input(logic [rmac_pkg::IN_W-1:0] v);
        return {{(W - rmac_pkg::IN_W){v[rmac_pkg::IN_W-1]}}, v}
               << (rmac_pkg::FRAC_BITS - rmac_pkg::IN_FRAC);
    endfunction

    rmac_alu u_alu (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (alu_req),
        .a      (opa_reg),
        .b      (opb),
        .resp   (alu_resp),
        .result (alu_result)
    );

    // effective limit and addressing
    assign uop        = rmac_pkg::uop_rom(pc_reg);
    assign lim        = (max_iter_reg > rmac_pkg::ITER_LIMIT) ? rmac_pkg::ITER_LIMIT
                                                              : max_iter_reg;
    assign phase_base = {1'b0, lim} - {1'b0, iter_reg};
    assign rf_raddr   = (state_reg == rmac_pkg::ST_RDA) ? uop.srca[rmac_pkg::RF_AW-1:0]
                                                        : uop.srcb[rmac_pkg::RF_AW-1:0];
    assign hist_waddr = iter_reg[rmac_pkg::HIST_AW-1:0];
    assign hist_raddr = iter_reg[rmac_pkg::HIST_AW:1];
    assign opa_src    = pick(uop.srca, rf_rd_reg, hre_rd_reg, him_rd_reg, in_re_reg, in_im_reg);
    assign opb        = pick(uop.srcb, rf_rd_reg, hre_rd_reg, him_rd_reg, in_re_reg, in_im_reg);

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_iter_reg <= rmac_pkg::MAX_ITER_RESET;
        end
        else if (cfg_we)
        begin
            max_iter_reg <= cfg_wdata;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rmac_pkg::ST_IDLE;
            pc_reg        <= '0;
            iter_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pc_reg        <= pc_next;
            iter_reg      <= iter_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        in_re_reg <= in_re_next;
        in_im_reg <= in_im_next;
        opa_reg   <= opa_next;
        class_reg <= class_next;
        used_reg  <= used_next;
    end

    // register file for orbit arithmetic
    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_mem[uop.dst] <= alu_result;
        end
        rf_rd_reg <= rf_mem[rf_raddr];
    end

    // orbit history
    always_ff @(posedge clk)
    begin
        if (rf_we && uop.hre)
        begin
            hre_mem[hist_waddr] <= alu_result;
        end
        if (rf_we && uop.him)
        begin
            him_mem[hist_waddr] <= alu_result;
        end
        hre_rd_reg <= hre_mem[hist_raddr];
        him_rd_reg <= him_mem[hist_raddr];
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        pc_next        = pc_reg;
        iter_next      = iter_reg;
        in_re_next     = in_re_reg;
        in_im_next     = in_im_reg;
        opa_next       = opa_reg;
        out_valid_next = out_valid_reg;
        class_next     = class_reg;
        used_next      = used_reg;
        alu_req.start  = 1'b0;
        alu_req.op     = uop.op;
        rf_we          = 1'b0;

        case (state_reg)
            rmac_pkg::ST_IDLE:
            begin
                if (point_in.valid)
                begin
                    in_re_next = load_input(point_in.point_re);
                    in_im_next = load_input(point_in.point_im);
                    pc_next    = '0;
                    iter_next  = '0;
                    state_next = rmac_pkg::ST_RDA;
                end
            end

            rmac_pkg::ST_RDA:
            begin
                state_next = rmac_pkg::ST_RDB;
            end

            rmac_pkg::ST_RDB:
            begin
                opa_next   = opa_src;
                state_next = rmac_pkg::ST_EXEC;
            end

            rmac_pkg::ST_EXEC:
            begin
                state_next = rmac_pkg::ST_RDA;
                pc_next    = pc_reg + rmac_pkg::PC_W'(1);
                case (uop.op)
                    rmac_pkg::OP_CHKZ:
                    begin
                        if (opa_reg == '0)
                        begin
                            class_next = rmac_pkg::CLASS_UNDECIDED;
                            used_next  = iter_reg;
                            state_next = rmac_pkg::ST_OUT;
                        end
                    end
                    rmac_pkg::OP_NEAR0:
                    begin
                        if ($signed(opa_reg) < $signed(rmac_pkg::SMALL_LIMIT))
                        begin
                            class_next = {1'b0, rmac_pkg::mod3(phase_base)};
                            used_next  = iter_reg;
                            state_next = rmac_pkg::ST_OUT;
                        end
                    end
                    rmac_pkg::OP_ESC:
                    begin
                        if ($signed(opa_reg) > $signed(rmac_pkg::BIG_LIMIT) ||
                            opa_reg == rmac_pkg::FX_MAX)
                        begin
                            class_next = {1'b0, rmac_pkg::mod3(phase_base + (IW+1)'(1))};
                            used_next  = iter_reg;
                            state_next = rmac_pkg::ST_OUT;
                        end
                    end
                    rmac_pkg::OP_NEAR1:
                    begin
                        if ($signed(opa_reg) < $signed(rmac_pkg::SMALL_LIMIT))
                        begin
                            class_next = {1'b0, rmac_pkg::mod3(phase_base + (IW+1)'(2))};
                            used_next  = iter_reg;
                            state_next = rmac_pkg::ST_OUT;
                        end
                    end
                    rmac_pkg::OP_CYC:
                    begin
                        if ($signed(opa_reg) < $signed(rmac_pkg::SMALL_LIMIT))
                        begin
                            class_next = rmac_pkg::CLASS_CYCLE;
                            used_next  = iter_reg;
                            state_next = rmac_pkg::ST_OUT;
                        end
                    end
                    rmac_pkg::OP_INIT:
                    begin
                        iter_next = IW'(1);
                    end
                    rmac_pkg::OP_LOOP:
                    begin
                        if (iter_reg >= lim)
                        begin
                            class_next = rmac_pkg::CLASS_UNDECIDED;
                            used_next  = lim;
                            state_next = rmac_pkg::ST_OUT;
                        end
                    end
                    rmac_pkg::OP_NEXT:
                    begin
                        iter_next = iter_reg + IW'(1);
                        pc_next   = rmac_pkg::LOOP_PC;
                    end
                    default:
                    begin
                        // arithmetic goes to the shared unit
                        alu_req.start = 1'b1;
                        pc_next       = pc_reg;
                        state_next    = rmac_pkg::ST_WAIT;
                    end
                endcase
                if (state_next == rmac_pkg::ST_OUT)
                begin
                    out_valid_next = 1'b1;
                end
            end

            rmac_pkg::ST_WAIT:
            begin
                if (alu_resp.done)
                begin
                    rf_we      = 1'b1;
                    pc_next    = pc_reg + rmac_pkg::PC_W'(1);
                    state_next = rmac_pkg::ST_RDA;
                end
            end

            rmac_pkg::ST_OUT:
            begin
                if (result_out.ready)
                begin
                    out_valid_next = 1'b0;
                    state_next     = rmac_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = rmac_pkg::ST_IDLE;
            end
        endcase
    end

    assign point_in.ready             = (state_reg == rmac_pkg::ST_IDLE);
    assign result_out.valid           = out_valid_reg;
    assign result_out.class_code      = class_reg;
    assign result_out.iterations_used = used_reg;

endmodule
